>>> sv/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// shared types and constants of the domain pdu parser
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // decoupling queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [15:0] USER_BIAS = 16'd1001;

  typedef enum logic [2:0] {
    CFG_ERECT  = 3'd0,
    CFG_ATTACH = 3'd1,
    CFG_JOIN   = 3'd2,
    CFG_DISC   = 3'd3,
    CFG_SEND   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    K_ERECT   = 3'd0,
    K_ATTACH  = 3'd1,
    K_JOIN    = 3'd2,
    K_DISC    = 3'd3,
    K_SEND    = 3'd4,
    K_UNKNOWN = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_SHORT   = 3'd2,
    ST_BADLEN  = 3'd3,
    ST_TRUNC   = 3'd4
  } status_t;

  typedef enum logic {
    OUT_PAYLOAD = 1'b0,
    OUT_SUMMARY = 1'b1
  } out_kind_t;

  // one queue entry: up to one payload byte plus an optional summary
  typedef struct packed {
    logic        has_pay;
    logic        has_sum;
    kind_t       kind;
    status_t     status;
    logic [15:0] user_id;
    logic [15:0] chan_id;
    logic [2:0]  reason;
    logic [13:0] plen;
    logic [15:0] cons;
    logic [7:0]  pbyte;
  } entry_t;

  // one result as seen on the output ports
  typedef struct packed {
    out_kind_t   okind;
    kind_t       kind;
    status_t     status;
    logic [15:0] user_id;
    logic [15:0] chan_id;
    logic [2:0]  reason;
    logic [13:0] plen;
    logic [15:0] cons;
    logic [7:0]  pbyte;
    logic        last;
  } result_t;

endpackage

>>> sv/domain_pdu_parser.sv
// ----------------------------------------------------------------------------
// domain_pdu_parser
// streaming parser for domain pdus, one byte per transfer
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         push / full            in_byte, in_last
// result    out        empty / pop            out_kind .. out_last (10 fields)
// config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// one byte is taken every cycle while full is low; the front classifies it in
//   the same cycle; results pass through the queue, then the output register
// a last byte that carries payload gives two results, sent one after the other
//   by the back; a four-entry queue between front and back absorbs them
// full rises only when that queue is full, so a stalled consumer backs up
//   the input after four queued entries plus the output register
// rst_n is synchronous: per-pdu state clears, type codes return to defaults
// ----------------------------------------------------------------------------
module domain_pdu_parser import dpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // input bytes
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  // results
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_kind,
  output logic [2:0]           out_pdu_kind,
  output logic [2:0]           out_status,
  output logic [15:0]          out_user_id,
  output logic [15:0]          out_chan_id,
  output logic [2:0]           out_disconnect_reason,
  output logic [13:0]          out_payload_len,
  output logic [15:0]          out_bytes_consumed,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last
);

  // front to queue
  logic    q_full;
  logic    q_push;
  entry_t  q_in;
  // queue to back
  logic    q_valid;
  logic    q_pop;
  entry_t  q_head;
  // output register contents
  result_t res;

  // classification, header capture, length decode, summary status
  dpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .push      (push),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // decoupling queue, one entry per byte that produces any result
  dpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_entry (q_in),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .q_valid  (q_valid),
    .rd_entry (q_head)
  );

  // splits entries into payload then summary transfers
  dpp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  // unpack the output register onto the result ports
  assign out_kind              = res.okind;
  assign out_pdu_kind          = res.kind;
  assign out_status            = res.status;
  assign out_user_id           = res.user_id;
  assign out_chan_id           = res.chan_id;
  assign out_disconnect_reason = res.reason;
  assign out_payload_len       = res.plen;
  assign out_bytes_consumed    = res.cons;
  assign out_payload_byte      = res.pbyte;
  assign out_last              = res.last;

endmodule

>>> sv/dpp_front.sv
// ----------------------------------------------------------------------------
// dpp_front
// accepts pdu bytes, classifies the pdu and captures its header fields
// ----------------------------------------------------------------------------
module dpp_front import dpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 push,
  output logic                 full,
  input  logic                 q_full,
  output logic                 q_push,
  output entry_t               q_entry
);

  localparam logic [15:0] POS_USER_HI = 16'd1;
  localparam logic [15:0] POS_USER_LO = 16'd2;
  localparam logic [15:0] POS_CHAN_HI = 16'd3;
  localparam logic [15:0] POS_CHAN_LO = 16'd4;
  localparam logic [15:0] POS_LEN_0   = 16'd6;
  localparam logic [15:0] POS_LEN_1   = 16'd7;
  localparam logic [15:0] PAY_START   = 16'd7;

  logic [7:0]  erect_r, attach_r, join_r, disc_r, send_r;
  logic [15:0] idx_r;
  kind_t       kind_r, kind_nxt;
  logic [15:0] user_r, user_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [2:0]  reason_r, reason_nxt;
  logic [13:0] len_r, len_nxt;
  logic        long_r, long_nxt;
  status_t     err_r, err_nxt;

  logic        accept;
  logic [15:0] start_pos;
  logic [16:0] end_pos;
  logic [16:0] cnt;
  logic [15:0] sat;
  logic        pay_hit;
  status_t     sum_st;
  logic [15:0] sum_cons;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    kind_nxt   = kind_r;
    user_nxt   = user_r;
    chan_nxt   = chan_r;
    reason_nxt = reason_r;
    len_nxt    = len_r;
    long_nxt   = long_r;
    err_nxt    = err_r;
    if (idx_r == '0) begin
      // lowest kind wins when codes coincide
      if (in_byte == erect_r) begin
        kind_nxt = K_ERECT;
      end else if (in_byte == attach_r) begin
        kind_nxt = K_ATTACH;
      end else if (in_byte == join_r) begin
        kind_nxt = K_JOIN;
      end else if (in_byte == disc_r) begin
        kind_nxt = K_DISC;
      end else if (in_byte == send_r) begin
        kind_nxt = K_SEND;
      end else begin
        kind_nxt = K_UNKNOWN;
        err_nxt  = ST_UNKNOWN;
      end
    end else if (err_r == ST_OK) begin
      if (kind_r == K_JOIN || kind_r == K_SEND) begin
        if (idx_r == POS_USER_HI) begin
          user_nxt = {in_byte, 8'h00};
        end else if (idx_r == POS_USER_LO) begin
          user_nxt = {user_r[15:8], in_byte};
        end else if (idx_r == POS_CHAN_HI) begin
          chan_nxt = {in_byte, 8'h00};
        end else if (idx_r == POS_CHAN_LO) begin
          chan_nxt = {chan_r[15:8], in_byte};
        end
      end
      if (kind_r == K_DISC && idx_r == POS_USER_HI) begin
        reason_nxt = in_byte[7:5];
      end
      if (kind_r == K_SEND) begin
        if (idx_r == POS_LEN_0) begin
          if (!in_byte[7]) begin
            len_nxt = {6'd0, in_byte};
          end else if (!in_byte[6]) begin
            long_nxt = 1'b1;
            len_nxt  = {in_byte[5:0], 8'h00};
          end else begin
            err_nxt = ST_BADLEN;
          end
        end else if (idx_r == POS_LEN_1 && long_r) begin
          len_nxt = {len_r[13:8], in_byte};
        end
      end
    end

    start_pos = PAY_START + {15'd0, long_nxt};
    end_pos   = {1'b0, start_pos} + {3'd0, len_nxt};
    pay_hit   = (err_nxt == ST_OK) && (kind_nxt == K_SEND) && (idx_r >= start_pos)
                && ({1'b0, idx_r} < end_pos);

    cnt = {1'b0, idx_r} + 17'd1;
    sat = (&idx_r) ? 16'hffff : cnt[15:0];
    sum_st   = err_nxt;
    sum_cons = sat;
    if (err_nxt == ST_OK) begin
      case (kind_nxt)
        K_ATTACH: sum_cons = 16'd1;
        K_JOIN: begin
          if (cnt < 17'd5) sum_st = ST_SHORT;
          else sum_cons = 16'd5;
        end
        K_DISC: begin
          if (cnt < 17'd2) sum_st = ST_SHORT;
          else sum_cons = 16'd2;
        end
        K_SEND: begin
          if (cnt < 17'd7 || (long_nxt && cnt < 17'd8)) sum_st = ST_SHORT;
          else if (cnt < end_pos) sum_st = ST_TRUNC;
          else sum_cons = end_pos[15:0];
        end
        default: sum_cons = sat;
      endcase
    end

    q_entry.has_pay    = pay_hit;
    q_entry.has_sum    = in_last;
    q_entry.kind       = kind_nxt;
    q_entry.status     = sum_st;
    q_entry.user_id    = user_nxt + USER_BIAS;
    q_entry.chan_id    = chan_nxt;
    q_entry.reason     = reason_nxt;
    q_entry.plen       = len_nxt;
    q_entry.cons       = sum_cons;
    q_entry.pbyte      = in_byte;
    q_push             = accept && (pay_hit || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erect_r  <= 8'd4;
      attach_r <= 8'd40;
      join_r   <= 8'd56;
      disc_r   <= 8'd32;
      send_r   <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ERECT:  erect_r  <= cfg_data;
        CFG_ATTACH: attach_r <= cfg_data;
        CFG_JOIN:   join_r   <= cfg_data;
        CFG_DISC:   disc_r   <= cfg_data;
        CFG_SEND:   send_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      idx_r    <= '0;
      kind_r   <= K_ERECT;
      user_r   <= '0;
      chan_r   <= '0;
      reason_r <= '0;
      len_r    <= '0;
      long_r   <= 1'b0;
      err_r    <= ST_OK;
    end else if (accept) begin
      idx_r    <= sat;
      kind_r   <= kind_nxt;
      user_r   <= user_nxt;
      chan_r   <= chan_nxt;
      reason_r <= reason_nxt;
      len_r    <= len_nxt;
      long_r   <= long_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

>>> sv/dpp_queue.sv
// ----------------------------------------------------------------------------
// dpp_queue
// short first-in first-out queue of parsed entries between front and back
// ----------------------------------------------------------------------------
module dpp_queue import dpp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_entry,
  output logic   q_full,
  input  logic   rd_en,
  output logic   q_valid,
  output entry_t rd_entry
);

  entry_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  assign q_full   = (count_r == (QAW+1)'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> sv/dpp_back.sv
// ----------------------------------------------------------------------------
// dpp_back
// expands queue entries into payload and summary results, output register
// ----------------------------------------------------------------------------
module dpp_back import dpp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  entry_t  q_head,
  output logic    q_pop,
  output logic    empty,
  input  logic    pop,
  output result_t res
);

  logic    out_valid_r, out_valid_nxt;
  logic    pay_done_r, pay_done_nxt;
  result_t res_r, res_nxt;
  result_t pay_res, sum_res;
  logic    take;
  logic    sum_ok;

  assign empty = !out_valid_r;
  assign res   = res_r;

  always_comb begin
    pay_res.okind      = OUT_PAYLOAD;
    pay_res.kind       = q_head.kind;
    pay_res.status     = ST_OK;
    pay_res.user_id    = q_head.user_id;
    pay_res.chan_id    = q_head.chan_id;
    pay_res.reason     = '0;
    pay_res.plen       = q_head.plen;
    pay_res.cons       = '0;
    pay_res.pbyte      = q_head.pbyte;
    pay_res.last       = 1'b0;

    // error summaries carry only kind, status and the byte count
    sum_ok             = (q_head.status == ST_OK);
    sum_res.okind      = OUT_SUMMARY;
    sum_res.kind       = q_head.kind;
    sum_res.status     = q_head.status;
    sum_res.user_id    = (sum_ok && (q_head.kind == K_JOIN || q_head.kind == K_SEND))
                         ? q_head.user_id : '0;
    sum_res.chan_id    = (sum_ok && (q_head.kind == K_JOIN || q_head.kind == K_SEND))
                         ? q_head.chan_id : '0;
    sum_res.reason     = (sum_ok && q_head.kind == K_DISC) ? q_head.reason : '0;
    sum_res.plen       = (sum_ok && q_head.kind == K_SEND) ? q_head.plen : '0;
    sum_res.cons       = q_head.cons;
    sum_res.pbyte      = '0;
    sum_res.last       = 1'b1;

    take          = q_valid && (!out_valid_r || pop);
    out_valid_nxt = out_valid_r && !pop;
    pay_done_nxt  = pay_done_r;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    if (take) begin
      out_valid_nxt = 1'b1;
      if (q_head.has_pay && !pay_done_r) begin
        res_nxt = pay_res;
        if (q_head.has_sum) begin
          pay_done_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        res_nxt      = sum_res;
        q_pop        = 1'b1;
        pay_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pay_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pay_done_r  <= pay_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

>>> dv/dpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_checker
// watches the byte, result and register ports of the domain pdu parser,
// predicts every result from the accepted bytes and compares in order
// ----------------------------------------------------------------------------
module dpp_checker import dpp_pkg::*; #(
  parameter logic [4:0][7:0] DEFAULT_CODES = '0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 push,
  input  logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 out_kind,
  input  logic [2:0]           out_pdu_kind,
  input  logic [2:0]           out_status,
  input  logic [15:0]          out_user_id,
  input  logic [15:0]          out_chan_id,
  input  logic [2:0]           out_disconnect_reason,
  input  logic [13:0]          out_payload_len,
  input  logic [15:0]          out_bytes_consumed,
  input  logic [7:0]           out_payload_byte,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending_results
);

  logic [4:0][7:0] codes;

  // per-pdu parse state
  logic [15:0] pdu_pos;
  kind_t       cur_kind;
  logic [15:0] user_wire;
  logic [15:0] chan_field;
  logic [2:0]  rsn_field;
  logic [13:0] len_field;
  logic        long_len;
  status_t     pdu_err;

  result_t     parsed_q[$];

  function automatic void clear_pdu();
    pdu_pos    = '0;
    cur_kind   = K_ERECT;
    user_wire  = '0;
    chan_field = '0;
    rsn_field  = '0;
    len_field  = '0;
    long_len   = 1'b0;
    pdu_err    = ST_OK;
  endfunction

  function automatic result_t form_result(out_kind_t ok, status_t st, logic [15:0] uid,
                                          logic [15:0] cid, logic [2:0] rsn,
                                          logic [13:0] plen, logic [15:0] cons,
                                          logic [7:0] pb, logic lst);
    result_t r;
    r.okind      = ok;
    r.kind       = cur_kind;
    r.status     = st;
    r.user_id    = uid;
    r.chan_id    = cid;
    r.reason     = rsn;
    r.plen       = plen;
    r.cons       = cons;
    r.pbyte      = pb;
    r.last       = lst;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    int      idx;
    int      first_pay;
    int      count;
    int      sat;
    int      cons;
    status_t st;
    logic    ids;
    idx = pdu_pos;
    if (idx == 0) begin
      if (b == codes[CFG_ERECT]) cur_kind = K_ERECT;
      else if (b == codes[CFG_ATTACH]) cur_kind = K_ATTACH;
      else if (b == codes[CFG_JOIN]) cur_kind = K_JOIN;
      else if (b == codes[CFG_DISC]) cur_kind = K_DISC;
      else if (b == codes[CFG_SEND]) cur_kind = K_SEND;
      else begin
        cur_kind = K_UNKNOWN;
        pdu_err  = ST_UNKNOWN;
      end
    end else if (pdu_err == ST_OK) begin
      if (cur_kind == K_JOIN || cur_kind == K_SEND) begin
        case (idx)
          1: user_wire[15:8]  = b;
          2: user_wire[7:0]   = b;
          3: chan_field[15:8] = b;
          4: chan_field[7:0]  = b;
          default: ;
        endcase
      end
      if (cur_kind == K_DISC && idx == 1) rsn_field = b[7:5];
      if (cur_kind == K_SEND) begin
        if (idx == 6) begin
          if (!b[7]) begin
            len_field = {7'b0, b[6:0]};
          end else if (b[7:6] == 2'b10) begin
            long_len  = 1'b1;
            len_field = {b[5:0], 8'h00};
          end else begin
            pdu_err = ST_BADLEN;
          end
        end else if (idx == 7 && long_len) begin
          len_field[7:0] = b;
        end
        first_pay = 7 + long_len;
        if (pdu_err == ST_OK && idx >= first_pay && idx < first_pay + len_field)
          parsed_q.push_back(form_result(OUT_PAYLOAD, ST_OK, user_wire + USER_BIAS,
                                         chan_field, 3'd0, len_field, 16'd0, b, 1'b0));
      end
    end

    if (lst) begin
      count     = idx + 1;
      sat       = (count > 65535) ? 65535 : count;
      st        = pdu_err;
      cons      = sat;
      first_pay = 7 + long_len;
      if (st == ST_OK) begin
        case (cur_kind)
          K_ATTACH: cons = 1;
          K_JOIN: if (count < 5) st = ST_SHORT; else cons = 5;
          K_DISC: if (count < 2) st = ST_SHORT; else cons = 2;
          K_SEND: begin
            if (count < 7 || (long_len && count < 8)) st = ST_SHORT;
            else if (count < first_pay + len_field) st = ST_TRUNC;
            else cons = first_pay + len_field;
          end
          default: ;
        endcase
      end
      if (st != ST_OK) begin
        parsed_q.push_back(form_result(OUT_SUMMARY, st, 16'd0, 16'd0, 3'd0, 14'd0,
                                       16'(sat), 8'd0, 1'b1));
      end else begin
        ids = (cur_kind == K_JOIN || cur_kind == K_SEND);
        parsed_q.push_back(form_result(OUT_SUMMARY, ST_OK,
                                       ids ? 16'(user_wire + USER_BIAS) : 16'd0,
                                       ids ? chan_field : 16'd0,
                                       (cur_kind == K_DISC) ? rsn_field : 3'd0,
                                       (cur_kind == K_SEND) ? len_field : 14'd0,
                                       16'(cons), 8'd0, 1'b1));
      end
      clear_pdu();
    end else if (pdu_pos != 16'hffff) begin
      pdu_pos = pdu_pos + 16'd1;
    end
  endtask

  task automatic note_field(input string fname, input logic [15:0] exp_v,
                            input logic [15:0] act_v, inout logic bad);
    if (exp_v !== act_v) begin
      if (fail_count < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, fname, exp_v, act_v);
      bad = 1'b1;
    end
  endtask

  task automatic check_result();
    result_t want;
    logic    bad;
    if (parsed_q.size() == 0) begin
      if (fail_count < 10) $display("%0t: result with nothing outstanding", $realtime);
      fail_count++;
    end else begin
      want = parsed_q.pop_front();
      bad  = 1'b0;
      note_field("out_kind", 16'(want.okind), 16'(out_kind), bad);
      note_field("out_pdu_kind", 16'(want.kind), 16'(out_pdu_kind), bad);
      note_field("out_status", 16'(want.status), 16'(out_status), bad);
      note_field("out_user_id", want.user_id, out_user_id, bad);
      note_field("out_chan_id", want.chan_id, out_chan_id, bad);
      note_field("out_disconnect_reason", 16'(want.reason), 16'(out_disconnect_reason), bad);
      note_field("out_payload_len", 16'(want.plen), 16'(out_payload_len), bad);
      note_field("out_bytes_consumed", want.cons, out_bytes_consumed, bad);
      note_field("out_payload_byte", 16'(want.pbyte), 16'(out_payload_byte), bad);
      note_field("out_last", 16'(want.last), 16'(out_last), bad);
      if (bad) fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      codes = DEFAULT_CODES;
      clear_pdu();
      parsed_q.delete();
    end else begin
      if (pop && !empty) check_result();
      if (cfg_we && cfg_index <= CFG_SEND) codes[cfg_index] = cfg_data;
      if (push && !full) parse_byte(in_byte, in_last);
    end
    pending_results <= parsed_q.size();
  end

endmodule

>>> dv/tb_domain_pdu_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_domain_pdu_parser
// drives pdu byte streams into the domain pdu parser under several type-code
// settings, with random idling on both sides and one long consumer stall;
// dpp_checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_domain_pdu_parser;
  import dpp_pkg::*;

  // type codes after reset, erect domain in the low byte
  localparam logic [4:0][7:0] DEFAULT_CODES = {8'd100, 8'd32, 8'd56, 8'd40, 8'd4};

  localparam int    NUM_PHASES     = 10;
  localparam int    PHASE_BYTES    = 65;     // random bytes per code setting
  localparam int    HOLD_CYCLES    = 300;
  localparam int    SETTLE_CYCLES  = 8;
  localparam longint TIMEOUT_NS    = 5_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 push;
  logic                 full;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic                 empty;
  logic                 pop;
  logic                 out_kind;
  logic [2:0]           out_pdu_kind;
  logic [2:0]           out_status;
  logic [15:0]          out_user_id;
  logic [15:0]          out_chan_id;
  logic [2:0]           out_disconnect_reason;
  logic [13:0]          out_payload_len;
  logic [15:0]          out_bytes_consumed;
  logic [7:0]           out_payload_byte;
  logic                 out_last;
  int                   fail_count;
  int                   pending_results;

  // stimulus state
  logic [4:0][7:0] code_now;     // what the block is programmed with
  logic [4:0][7:0] code_set;
  logic [7:0]      pdu_bytes[$];
  int              random_bytes;
  bit              quiet;        // no idling on either side
  int              holds_asked;
  int              holds_done;

  domain_pdu_parser dut (.*);

  dpp_checker #(.DEFAULT_CODES(DEFAULT_CODES)) pdu_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random pop, plus a long hold-off on request so the
  // internal queue fills and full backs up the byte stream
  initial begin
    pop        = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!quiet && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic ship_pdu();
    foreach (pdu_bytes[i]) send_byte(pdu_bytes[i], i == pdu_bytes.size() - 1);
    random_bytes += pdu_bytes.size();
  endtask

  // stop offering bytes and wait until every predicted result is out
  task automatic drain();
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // a header byte with no result may still sit in the front
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across the five back-to-back writes
  task automatic program_codes(input logic [4:0][7:0] v);
    for (int i = 0; i <= CFG_SEND; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    code_now = v;
  endtask

  task automatic add_random(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) pdu_bytes.push_back(8'($urandom));
  endtask

  task automatic cut_to(input int n);
    while (pdu_bytes.size() > n) void'(pdu_bytes.pop_back());
  endtask

  // one pdu: mostly well-formed with random content, some short, truncated,
  // bad length form, unknown type or plain noise
  task automatic build_pdu(input bit send_only);
    int         pick;
    int         form;
    int         len_v;
    int         keep;
    logic [7:0] hi6;
    logic [7:0] lo8;
    logic [7:0] first_b;
    pdu_bytes.delete();
    pick = send_only ? 4 : $urandom_range(0, 9);
    case (pick)
      0: begin
        pdu_bytes.push_back(code_now[CFG_ERECT]);
        add_random(0, 5);
      end
      1: begin
        pdu_bytes.push_back(code_now[CFG_ATTACH]);
        add_random(0, 2);
      end
      2, 3: begin
        pdu_bytes.push_back(code_now[CFG_JOIN]);
        add_random(4, 4);
        if ($urandom_range(0, 4) == 0) cut_to($urandom_range(1, 4));
        else add_random(0, 2);
      end
      7: begin
        pdu_bytes.push_back(code_now[CFG_DISC]);
        add_random(1, 1);
        if ($urandom_range(0, 6) == 0) cut_to(1);
        else add_random(0, 2);
      end
      8: begin
        // first byte that matches none of the codes
        first_b = 8'($urandom);
        while (first_b == code_now[CFG_ERECT] || first_b == code_now[CFG_ATTACH] ||
               first_b == code_now[CFG_JOIN] || first_b == code_now[CFG_DISC] ||
               first_b == code_now[CFG_SEND])
          first_b = first_b + 8'd1;
        pdu_bytes.push_back(first_b);
        add_random(0, 3);
      end
      9: add_random(1, 6);
      default: begin
        // send data: ids, flags, then the length in one of its forms
        pdu_bytes.push_back(code_now[CFG_SEND]);
        add_random(5, 5);
        form = $urandom_range(0, 9);
        if (form == 9) begin
          pdu_bytes.push_back(8'hc0 | 8'($urandom_range(0, 63)));
          add_random(0, 3);
        end else begin
          if (form < 6) begin
            len_v = (form == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            pdu_bytes.push_back(8'(len_v));
          end else begin
            hi6 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 63)) : 8'd0;
            lo8 = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
            pdu_bytes.push_back(8'h80 | hi6);
            pdu_bytes.push_back(lo8);
            len_v = hi6 * 256 + lo8;
          end
          keep = $urandom_range(0, 9);
          if (len_v > 130) add_random(0, 30);   // big lengths only ever arrive cut off
          else if (keep < 7) add_random(len_v, len_v + 2);
          else if (keep < 9) add_random(0, (len_v > 0) ? len_v - 1 : 0);
          else cut_to($urandom_range(1, pdu_bytes.size() - 1));
        end
      end
    endcase
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ERECT;
    cfg_data     = '0;
    push         = 1'b0;
    in_byte      = '0;
    in_last      = 1'b0;
    quiet        = 1'b0;
    holds_asked  = 0;
    random_bytes = 0;
    code_now     = DEFAULT_CODES;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed pdus under the reset codes
    pdu_bytes = '{code_now[CFG_ATTACH]};
    ship_pdu();
    pdu_bytes = '{code_now[CFG_ERECT]};
    ship_pdu();
    // user id wraps past 65535, trailing byte ignored
    pdu_bytes = '{code_now[CFG_JOIN], 8'hff, 8'hff, 8'h00, 8'h00, 8'h7f};
    ship_pdu();
    pdu_bytes = '{code_now[CFG_DISC], 8'he0};
    ship_pdu();
    // disconnect cut short
    pdu_bytes = '{code_now[CFG_DISC]};
    ship_pdu();
    pdu_bytes = '{8'h00, 8'hff};
    ship_pdu();
    // two-byte length of one, last byte carries the payload
    pdu_bytes = '{code_now[CFG_SEND], 8'h12, 8'h34, 8'hab, 8'hcd, 8'h00, 8'h80, 8'h01, 8'h5a};
    ship_pdu();

    // random pdus, a fresh code setting per phase
    random_bytes = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        // extremes, with coinciding codes so the lowest kind must win
        0: code_set = {8'd128, 8'd255, 8'd0, 8'd255, 8'd0};
        1: code_set = DEFAULT_CODES;
        default: for (int i = 0; i <= CFG_SEND; i++) code_set[i] = 8'($urandom_range(0, 255));
      endcase
      program_codes(code_set);
      quiet = (ph == 1 || ph == 2);
      // payload-heavy phase while the consumer holds off
      if (ph == 2) holds_asked++;
      while (random_bytes < (ph + 1) * PHASE_BYTES) begin
        build_pdu(ph == 2);
        ship_pdu();
      end
    end
    quiet = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dpp_pkg.sv
sv/dpp_front.sv
sv/dpp_queue.sv
sv/dpp_back.sv
sv/domain_pdu_parser.sv
dv/dpp_checker.sv
dv/tb_domain_pdu_parser.sv
